/* rtl/dlpp_pkg.sv */
// ----------------------------------------------------------------------------
// dlpp_pkg
// Shared types and constants of the DVD LPCM packet packer.
// ----------------------------------------------------------------------------
package dlpp_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CH_W         = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 4;
  localparam int SMP_W        = 32;
  localparam int GRP_W        = 24;
  localparam int GRP_DEPTH    = 4;
  localparam int FILL_W       = 2;
  localparam int POS_W        = 4;
  localparam int JQ_DEPTH     = 2;
  localparam int JQ_PTR_W     = 1;
  localparam int JQ_CNT_W     = 2;

  localparam logic [7:0] HDR_FIRST = 8'h0C;
  localparam logic [7:0] HDR_LAST  = 8'h80;
  localparam logic [1:0] QUANT_16  = 2'd0;
  localparam logic [1:0] QUANT_24  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDE = 2'd0,
    CFG_RATE = 2'd1,
    CFG_CHAN = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BODY_NONE  = 2'd0,
    BODY_PCM16 = 2'd1,
    BODY_GROUP = 2'd2
  } body_e;

  typedef struct packed {
    logic                            hdr;
    logic [7:0]                      hdr_mid;
    body_e                           body;
    logic                            mono;
    logic                            eop;
    logic [GRP_DEPTH-1:0][GRP_W-1:0] smp;
  } job_t;

endpackage

/* rtl/dlpp_front.sv */
// ----------------------------------------------------------------------------
// dlpp_front
// Accepts samples, holds configuration and the 24-bit group, and turns each
// 16-bit sample, group or packet start into a byte job for the back end.
// ----------------------------------------------------------------------------
module dlpp_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [dlpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dlpp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 accept,
  input  logic signed [dlpp_pkg::SMP_W-1:0]    sample,
  input  logic                                 packet_start,
  input  logic                                 packet_end,
  output logic                                 job_push,
  output dlpp_pkg::job_t                       job
);

  logic                                        wide_r, wide_nxt;
  logic                                        rate_r, rate_nxt;
  logic [dlpp_pkg::CH_W-1:0]                   chan_r, chan_nxt;
  logic [dlpp_pkg::FILL_W-1:0]                 fill_r, fill_nxt;
  logic [dlpp_pkg::GRP_DEPTH-1:0][dlpp_pkg::GRP_W-1:0] grp_r, grp_nxt;

  logic [dlpp_pkg::FILL_W-1:0] idx;
  logic [dlpp_pkg::FILL_W-1:0] inc;
  logic [dlpp_pkg::CH_W-1:0]   ch_clamp;
  logic                        mono;
  logic                        complete;

  assign mono = (chan_r == dlpp_pkg::CH_W'(1));
  assign idx  = packet_start ? '0 : fill_r;
  assign inc  = idx + dlpp_pkg::FILL_W'(1);
  assign complete = wide_r && (inc == (mono ? dlpp_pkg::FILL_W'(2) : '0));

  always_comb begin
    if (cfg_data == '0) begin
      ch_clamp = dlpp_pkg::CH_W'(1);
    end else if (cfg_data > dlpp_pkg::CFG_DATA_W'(dlpp_pkg::MAX_CHANNELS)) begin
      ch_clamp = dlpp_pkg::CH_W'(dlpp_pkg::MAX_CHANNELS);
    end else begin
      ch_clamp = cfg_data;
    end
  end

  always_comb begin
    grp_nxt = grp_r;
    if (accept && wide_r) begin
      grp_nxt[idx] = sample[31:8];
    end
  end

  always_comb begin
    wide_nxt = wide_r;
    rate_nxt = rate_r;
    chan_nxt = chan_r;
    fill_nxt = fill_r;
    if (cfg_wr_en) begin
      case (dlpp_pkg::cfg_idx_e'(cfg_index))
        dlpp_pkg::CFG_WIDE: begin
          wide_nxt = cfg_data[0];
          fill_nxt = '0;
        end
        dlpp_pkg::CFG_RATE: rate_nxt = cfg_data[0];
        dlpp_pkg::CFG_CHAN: begin
          chan_nxt = ch_clamp;
          fill_nxt = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (!wide_r) begin
        fill_nxt = packet_start ? '0 : fill_r;
      end else if (complete || packet_end) begin
        fill_nxt = '0;
      end else begin
        fill_nxt = inc;
      end
    end
  end

  always_comb begin
    job.hdr     = packet_start;
    job.hdr_mid = {(wide_r ? dlpp_pkg::QUANT_24 : dlpp_pkg::QUANT_16), 1'b0, rate_r,
                   chan_r - dlpp_pkg::CH_W'(1)};
    job.mono    = mono;
    job.eop     = packet_end;
    job.smp     = grp_nxt;
    if (!wide_r) begin
      job.body   = dlpp_pkg::BODY_PCM16;
      job.smp[0] = {8'h00, sample[15:0]};
    end else if (complete) begin
      job.body = dlpp_pkg::BODY_GROUP;
    end else begin
      job.body = dlpp_pkg::BODY_NONE;
    end
  end

  assign job_push = accept && (packet_start || !wide_r || complete);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r <= 1'b0;
      rate_r <= 1'b0;
      chan_r <= dlpp_pkg::CH_W'(2);
      fill_r <= '0;
    end else begin
      wide_r <= wide_nxt;
      rate_r <= rate_nxt;
      chan_r <= chan_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r <= grp_nxt;
  end

endmodule

/* rtl/dlpp_job_fifo.sv */
// ----------------------------------------------------------------------------
// dlpp_job_fifo
// Two-entry job queue between front and back end.
// ----------------------------------------------------------------------------
module dlpp_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dlpp_pkg::job_t wr_job,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output dlpp_pkg::job_t rd_job
);

  dlpp_pkg::job_t                  mem_r [dlpp_pkg::JQ_DEPTH];
  logic [dlpp_pkg::JQ_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [dlpp_pkg::JQ_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [dlpp_pkg::JQ_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full    = (cnt_r == dlpp_pkg::JQ_CNT_W'(dlpp_pkg::JQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + dlpp_pkg::JQ_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + dlpp_pkg::JQ_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + dlpp_pkg::JQ_CNT_W'(do_push) - dlpp_pkg::JQ_CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule

/* rtl/dlpp_back.sv */
// ----------------------------------------------------------------------------
// dlpp_back
// Walks the head job byte by byte into the output register.
// ----------------------------------------------------------------------------
module dlpp_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_valid,
  input  dlpp_pkg::job_t           job,
  output logic                     job_pop,
  input  logic                     pop,
  output logic                     empty,
  output logic [7:0]               data_byte,
  output logic                     end_of_packet,
  output logic                     run_last
);

  logic [dlpp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [dlpp_pkg::POS_W-1:0] len;
  logic [dlpp_pkg::POS_W-1:0] hdr_len;
  logic [dlpp_pkg::POS_W-1:0] q;
  logic [dlpp_pkg::POS_W-1:0] g2;
  logic [dlpp_pkg::POS_W-1:0] ql;
  logic [7:0]                 byte_val;
  logic                       last;
  logic                       load;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r;
  logic                       out_eop_r;
  logic                       out_last_r;

  assign hdr_len = job.hdr ? dlpp_pkg::POS_W'(3) : '0;
  assign g2      = job.mono ? dlpp_pkg::POS_W'(4) : dlpp_pkg::POS_W'(8);
  assign q       = pos_r - hdr_len;
  assign ql      = q - g2;

  always_comb begin
    unique case (job.body)
      dlpp_pkg::BODY_PCM16: len = hdr_len + dlpp_pkg::POS_W'(2);
      dlpp_pkg::BODY_GROUP: len = hdr_len + (job.mono ? dlpp_pkg::POS_W'(6)
                                                      : dlpp_pkg::POS_W'(12));
      default:              len = hdr_len;
    endcase
  end

  always_comb begin
    if (job.hdr && pos_r == '0) begin
      byte_val = dlpp_pkg::HDR_FIRST;
    end else if (job.hdr && pos_r == dlpp_pkg::POS_W'(1)) begin
      byte_val = job.hdr_mid;
    end else if (job.hdr && pos_r == dlpp_pkg::POS_W'(2)) begin
      byte_val = dlpp_pkg::HDR_LAST;
    end else if (job.body == dlpp_pkg::BODY_PCM16) begin
      byte_val = q[0] ? job.smp[0][7:0] : job.smp[0][15:8];
    end else if (q < g2) begin
      byte_val = q[0] ? job.smp[q[2:1]][15:8] : job.smp[q[2:1]][23:16];
    end else begin
      byte_val = job.smp[ql[1:0]][7:0];
    end
  end

  assign last    = (pos_r == len - dlpp_pkg::POS_W'(1));
  assign load    = job_valid && (!out_valid_r || pop);
  assign job_pop = load && last;

  always_comb begin
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = last ? '0 : pos_r + dlpp_pkg::POS_W'(1);
    end
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r <= byte_val;
      out_eop_r  <= last && job.eop;
      out_last_r <= last;
    end
  end

  assign empty         = !out_valid_r;
  assign data_byte     = out_byte_r;
  assign end_of_packet = out_eop_r;
  assign run_last      = out_last_r;

  a_pos_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> pos_r < len)
    else $error("byte position past end of job");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !job_valid |-> pos_r == '0)
    else $error("byte position not cleared between jobs");

  a_eop_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eop_r) |-> out_last_r)
    else $error("end of packet on a byte that does not close its sample");

endmodule

/* rtl/dvd_lpcm_packet_packer_unit.sv */
// ----------------------------------------------------------------------------
// dvd_lpcm_packet_packer_unit
// DVD LPCM packer: samples in, packet bytes out with header and grouping.
// ----------------------------------------------------------------------------
// One byte leaves per cycle from a byte-wide output register while pop is
// asserted and a job waits. A sample makes 2 bytes in 16-bit mode, on average 3 in
// 24-bit mode (a group of 2 or 4 samples comes out as 6 or 12 bytes on the
// beat that completes it), plus 3 header bytes on a packet's first sample.
// A two-job queue lets samples be taken while earlier bytes are still
// draining; full rises only when both jobs are waiting.
module dvd_lpcm_packet_packer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [dlpp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dlpp_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 push,
  output logic                                 full,
  input  logic signed [dlpp_pkg::SMP_W-1:0]    in_sample,
  input  logic                                 in_packet_start,
  input  logic                                 in_packet_end,
  output logic                                 empty,
  input  logic                                 pop,
  output logic [7:0]                           out_data_byte,
  output logic                                 out_end_of_packet,
  output logic                                 out_run_last
);

  logic           accept;
  logic           job_push;
  logic           job_pop;
  logic           jq_empty;
  dlpp_pkg::job_t wr_job;
  dlpp_pkg::job_t rd_job;

  assign accept = push && !full;

  dlpp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .sample       (in_sample),
    .packet_start (in_packet_start),
    .packet_end   (in_packet_end),
    .job_push     (job_push),
    .job          (wr_job)
  );

  dlpp_job_fifo u_jq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (wr_job),
    .pop    (job_pop),
    .full   (full),
    .empty  (jq_empty),
    .rd_job (rd_job)
  );

  dlpp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid     (!jq_empty),
    .job           (rd_job),
    .job_pop       (job_pop),
    .pop           (pop),
    .empty         (empty),
    .data_byte     (out_data_byte),
    .end_of_packet (out_end_of_packet),
    .run_last      (out_run_last)
  );

endmodule
